// File: src/mvm_pkg.sv
// shared types, constants and width helpers for the matrix-vector multiplier
package mvm_pkg;

   localparam int MAX_DIM_DEFAULT = 16;

   // fixed field widths
   localparam int FUNC_W  = 2;
   localparam int ROW_W   = 4;
   localparam int COL_W   = 4;
   localparam int DATA_W  = 32;
   localparam int CFG_W   = 5;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int FRAC_W  = 16;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_MAT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_VEC  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CALC = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b1;

   localparam logic [CFG_W-1:0] CFG_DIM_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   // control travelling along the cell chain with each row
   typedef struct packed {
      logic valid;
      logic last;
   } tok_ctrl_type;

   // store write broadcast to every cell
   typedef struct packed {
      logic              mat_en;
      logic              vec_en;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } wr_bus_type;

   function automatic int idx_width(input int dim);
      return (dim > 1) ? $clog2(dim) : 1;
   endfunction

   function automatic int dim_width(input int dim);
      return $clog2(dim + 1);
   endfunction

   // exact sum of dim signed 64-bit products plus the rounding half
   function automatic int acc_width(input int dim);
      return PROD_W + 2 + $clog2(dim);
   endfunction

endpackage

// File: src/mvm_seq.sv
// configuration registers, load decode and row issue sequencer
module mvm_seq import mvm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [FUNC_W-1:0]               req_func,
   input  logic [ROW_W-1:0]                req_row_index,
   input  logic [COL_W-1:0]                req_col_index,
   input  logic [DATA_W-1:0]               req_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_IDX_W-1:0]            csr_index,
   input  logic [CFG_W-1:0]                csr_data,
   input  logic                            adv,
   input  logic                            done,
   output wr_bus_type                      wr,
   output tok_ctrl_type                    issue_ctrl,
   output logic [idx_width(MAX_DIM)-1:0]   issue_row,
   output logic [dim_width(MAX_DIM)-1:0]   cols
);

   localparam int IDX_W = idx_width(MAX_DIM);
   localparam int DIM_W = dim_width(MAX_DIM);

   state_type state_ff, state_in;

   logic [CFG_W-1:0] num_rows_ff;
   logic [CFG_W-1:0] num_cols_ff;
   logic [DIM_W-1:0] rows_ff;
   logic [DIM_W-1:0] cols_ff;
   logic [IDX_W-1:0] row_cnt_ff;
   logic [DIM_W-1:0] rows_clamp;
   logic [DIM_W-1:0] cols_clamp;
   logic             accept;
   logic             calc_start;
   logic             row_last;

   assign csr_ready = 1'b1;
   assign accept = req_valid && !req_stall;
   assign calc_start = accept && (req_func == FUNC_CALC);
   assign row_last = (DIM_W'(row_cnt_ff) == (rows_ff - DIM_W'(1)));

   // zero counts as one, anything above the array size as the array size
   always_comb begin
      if (num_rows_ff == '0) begin
         rows_clamp = DIM_W'(1);
      end else if (32'(num_rows_ff) > MAX_DIM) begin
         rows_clamp = DIM_W'(MAX_DIM);
      end else begin
         rows_clamp = DIM_W'(num_rows_ff);
      end
      if (num_cols_ff == '0) begin
         cols_clamp = DIM_W'(1);
      end else if (32'(num_cols_ff) > MAX_DIM) begin
         cols_clamp = DIM_W'(MAX_DIM);
      end else begin
         cols_clamp = DIM_W'(num_cols_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= CFG_DIM_RESET;
         num_cols_ff <= CFG_DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_ROWS: num_rows_ff <= csr_data;
            CSR_NUM_COLS: num_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (calc_start) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (adv && row_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (calc_start) begin
         rows_ff    <= rows_clamp;
         cols_ff    <= cols_clamp;
         row_cnt_ff <= '0;
      end else if (state_ff == ST_ISSUE && adv) begin
         row_cnt_ff <= row_cnt_ff + IDX_W'(1);
      end
   end

   // outputs
   always_comb begin
      req_stall        = 1'b1;
      issue_ctrl.valid = 1'b0;
      issue_ctrl.last  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_ISSUE: begin
            issue_ctrl.valid = 1'b1;
            issue_ctrl.last  = row_last;
         end
         ST_DRAIN: ;
         default:  ;
      endcase
   end

   assign issue_row = row_cnt_ff;
   assign cols      = cols_ff;

   // writes outside the array are dropped here
   assign wr.mat_en = accept && (req_func == FUNC_MAT)
                      && (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign wr.vec_en = accept && (req_func == FUNC_VEC) && (32'(req_col_index) < MAX_DIM);
   assign wr.row    = req_row_index;
   assign wr.col    = req_col_index;
   assign wr.value  = req_value;

endmodule

// File: src/mvm_cell.sv
// one column cell: holds a matrix column and a vector entry, adds its product to the passing sum
module mvm_cell import mvm_pkg::*; #(
   parameter int MAX_DIM  = MAX_DIM_DEFAULT,
   parameter int CELL_IDX = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  wr_bus_type                      wr,
   input  logic [dim_width(MAX_DIM)-1:0]   cols,
   input  tok_ctrl_type                    in_ctrl,
   input  logic [idx_width(MAX_DIM)-1:0]   in_row,
   input  logic [acc_width(MAX_DIM)-1:0]   in_acc,
   output tok_ctrl_type                    out_ctrl,
   output logic [idx_width(MAX_DIM)-1:0]   out_row,
   output logic [acc_width(MAX_DIM)-1:0]   out_acc
);

   localparam int IDX_W = idx_width(MAX_DIM);
   localparam int AW    = acc_width(MAX_DIM);

   logic [DATA_W-1:0] mem [MAX_DIM];
   logic [DATA_W-1:0] x_ff;
   logic [DATA_W-1:0] mem_q_ff;

   tok_ctrl_type      a_ctrl_ff, b_ctrl_ff, c_ctrl_ff;
   logic [IDX_W-1:0]  a_row_ff, b_row_ff, c_row_ff;
   logic [AW-1:0]     a_acc_ff, b_acc_ff, c_acc_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [AW-1:0]     c_acc_in;
   logic              col_used;
   logic              col_hit;

   assign col_hit  = (32'(wr.col) == CELL_IDX);
   assign col_used = (CELL_IDX < 32'(cols));

   // column store: written by load items, read by the row at the cell input
   always_ff @(posedge clock) begin
      if (wr.mat_en && col_hit) begin
         mem[IDX_W'(wr.row)] <= wr.value;
      end
      if (adv) begin
         mem_q_ff <= mem[in_row];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.vec_en && col_hit) begin
         x_ff <= wr.value;
      end
   end

   // columns beyond the active width contribute nothing
   always_comb begin
      if (col_used) begin
         prod_in = $signed(mem_q_ff) * $signed(x_ff);
      end else begin
         prod_in = '0;
      end
   end

   assign c_acc_in = b_acc_ff + {{(AW - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
         b_ctrl_ff <= '0;
         c_ctrl_ff <= '0;
      end else if (adv) begin
         a_ctrl_ff <= in_ctrl;
         b_ctrl_ff <= a_ctrl_ff;
         c_ctrl_ff <= b_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_row_ff <= in_row;
         a_acc_ff <= in_acc;
         b_row_ff <= a_row_ff;
         b_acc_ff <= a_acc_ff;
         prod_ff  <= prod_in;
         c_row_ff <= b_row_ff;
         c_acc_ff <= c_acc_in;
      end
   end

   assign out_ctrl = c_ctrl_ff;
   assign out_row  = c_row_ff;
   assign out_acc  = c_acc_ff;

endmodule

// File: src/mvm_out.sv
// rounding, saturation and the result register
module mvm_out import mvm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tok_ctrl_type                    in_ctrl,
   input  logic [idx_width(MAX_DIM)-1:0]   in_row,
   input  logic [acc_width(MAX_DIM)-1:0]   in_acc,
   output logic                            adv,
   output logic                            done,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ROW_W-1:0]                rsp_out_row,
   output logic [DATA_W-1:0]               rsp_out_value,
   output logic                            rsp_saturated,
   output logic                            rsp_last
);

   localparam int AW = acc_width(MAX_DIM);
   localparam int TOP_LSB = FRAC_W + DATA_W - 1;

   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [DATA_W-1:0] value_ff;
   logic              sat_ff;
   logic              last_ff;
   logic [AW-1:0]     sum;
   logic              fits;
   logic              neg;
   logic [DATA_W-1:0] value_in;

   // round half up, then check the bits above the result are all sign
   assign sum  = in_acc + AW'(32'h0000_8000);
   assign neg  = sum[AW-1];
   assign fits = (sum[AW-1:TOP_LSB] == '0) || (sum[AW-1:TOP_LSB] == '1);

   always_comb begin
      if (fits) begin
         value_in = sum[TOP_LSB:FRAC_W];
      end else if (neg) begin
         value_in = 32'h8000_0000;
      end else begin
         value_in = 32'h7FFF_FFFF;
      end
   end

   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign done = rsp_valid_ff && !rsp_stall && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_ctrl.valid) begin
         row_ff   <= ROW_W'(in_row);
         value_ff <= value_in;
         sat_ff   <= !fits;
         last_ff  <= in_ctrl.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_value = value_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last      = last_ff;

endmodule

// File: src/matrix_vector_multiply.sv
// matrix-vector multiplier: a chain of column cells summing one row per cycle unless the result output stalls
// load items (matrix or vector entry) are taken one per cycle while no compute is running
// a compute item sends its rows through each cell's a, b and c registers and the result
// register, giving one result per cycle while rsp_stall is low; the next item is taken
// once the last row is delivered
// reset sets num_rows and num_cols to 16; the stores hold nothing until written
module matrix_vector_multiply import mvm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [ROW_W-1:0]       req_row_index,
   input  logic [COL_W-1:0]       req_col_index,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ROW_W-1:0]       rsp_out_row,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                   rsp_saturated,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   localparam int IDX_W = idx_width(MAX_DIM);
   localparam int DIM_W = dim_width(MAX_DIM);
   localparam int AW    = acc_width(MAX_DIM);

   wr_bus_type       wr;
   logic             adv;
   logic             done;
   logic [DIM_W-1:0] cols;
   logic [DATA_W-1:0] value_out;

   tok_ctrl_type     chain_ctrl [MAX_DIM+1];
   logic [IDX_W-1:0] chain_row  [MAX_DIM+1];
   logic [AW-1:0]    chain_acc  [MAX_DIM+1];

   mvm_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_value     (req_value),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .adv           (adv),
      .done          (done),
      .wr            (wr),
      .issue_ctrl    (chain_ctrl[0]),
      .issue_row     (chain_row[0]),
      .cols          (cols)
   );

   assign chain_acc[0] = '0;

   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      mvm_cell #(
         .MAX_DIM  (MAX_DIM),
         .CELL_IDX (c)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .wr       (wr),
         .cols     (cols),
         .in_ctrl  (chain_ctrl[c]),
         .in_row   (chain_row[c]),
         .in_acc   (chain_acc[c]),
         .out_ctrl (chain_ctrl[c+1]),
         .out_row  (chain_row[c+1]),
         .out_acc  (chain_acc[c+1])
      );
   end

   mvm_out #(
      .MAX_DIM (MAX_DIM)
   ) u_out (
      .clock         (clock),
      .reset         (reset),
      .in_ctrl       (chain_ctrl[MAX_DIM]),
      .in_row        (chain_row[MAX_DIM]),
      .in_acc        (chain_acc[MAX_DIM]),
      .adv           (adv),
      .done          (done),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_value (value_out),
      .rsp_saturated (rsp_saturated),
      .rsp_last      (rsp_last)
   );

   assign rsp_out_value = value_out;

endmodule

// File: tb/mvm_checker.sv
// checker for the matrix-vector multiplier: mirrors the stores, predicts each row product
`timescale 1ns / 1ps

module mvm_checker import mvm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [ROW_W-1:0]         req_row_index,
   input  logic [COL_W-1:0]         req_col_index,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [ROW_W-1:0]         rsp_out_row,
   input  logic signed [DATA_W-1:0] rsp_out_value,
   input  logic                     rsp_saturated,
   input  logic                     rsp_last,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_data,
   output int                       failure_count,
   output int                       pending_results
);

   localparam int DIM = MAX_DIM_DEFAULT;
   localparam int ACC_W = 72;
   localparam logic signed [ACC_W-1:0] POS_LIMIT = 72'sh7FFFFFFF;
   localparam logic signed [ACC_W-1:0] NEG_LIMIT = -72'sh80000000;
   localparam logic signed [ACC_W-1:0] HALF_LSB = 72'sh8000;

   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic signed [DATA_W-1:0] value;
      logic                     saturated;
      logic                     last;
   } row_result_type;

   logic signed [DATA_W-1:0] matrix_copy [DIM][DIM];
   logic signed [DATA_W-1:0] vector_copy [DIM];
   logic [CFG_W-1:0] rows_reg = CFG_DIM_RESET;
   logic [CFG_W-1:0] cols_reg = CFG_DIM_RESET;
   row_result_type product_queue [$];
   row_result_type oldest;
   int mismatches = 0;

   assign failure_count = mismatches;

   function automatic int clamp_dim(input logic [CFG_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM) return DIM;
      return int'(d);
   endfunction

   // exact sum of Q32.32 products, round half up to Q16.16, then clip
   function automatic row_result_type predict_row(input int r, input int cols, input int rows);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] rounded;
      logic signed [2*DATA_W-1:0] prod;
      row_result_type res;
      acc = '0;
      for (int c = 0; c < cols; c++) begin
         prod = matrix_copy[r][c] * vector_copy[c];
         acc = acc + prod;
      end
      rounded = (acc + HALF_LSB) >>> FRAC_W;
      res.row = r[ROW_W-1:0];
      res.last = (r + 1 == rows);
      res.saturated = 1'b1;
      if (rounded > POS_LIMIT) begin
         res.value = 32'sh7FFFFFFF;
      end else if (rounded < NEG_LIMIT) begin
         res.value = 32'sh80000000;
      end else begin
         res.value = rounded[DATA_W-1:0];
         res.saturated = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rows_reg = CFG_DIM_RESET;
         cols_reg = CFG_DIM_RESET;
         product_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (product_queue.size() == 0) begin
               $error("result for row %0d arrived with nothing expected", rsp_out_row);
               mismatches++;
            end else begin
               oldest = product_queue.pop_front();
               if (rsp_out_row !== oldest.row) begin
                  $error("out_row: expected %0d, got %0d", oldest.row, rsp_out_row);
                  mismatches++;
               end
               if (rsp_out_value !== oldest.value) begin
                  $error("out_value: expected %h, got %h", oldest.value, rsp_out_value);
                  mismatches++;
               end
               if (rsp_saturated !== oldest.saturated) begin
                  $error("saturated: expected %0b, got %0b", oldest.saturated, rsp_saturated);
                  mismatches++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %0b, got %0b", oldest.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_ROWS: rows_reg = csr_data;
               CSR_NUM_COLS: cols_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_func)
               FUNC_MAT: matrix_copy[req_row_index][req_col_index] = req_value;
               FUNC_VEC: vector_copy[req_col_index] = req_value;
               FUNC_CALC: begin
                  for (int r = 0; r < clamp_dim(rows_reg); r++)
                     product_queue.push_back(predict_row(r, clamp_dim(cols_reg),
                                                         clamp_dim(rows_reg)));
               end
               default: ;  // unused code, no effect
            endcase
         end
      end
      pending_results <= product_queue.size();
   end

endmodule

// File: tb/tb_matrix_vector_multiply.sv
// top testbench for the matrix-vector multiplier: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_matrix_vector_multiply;
   import mvm_pkg::*;

   localparam int DIM = MAX_DIM_DEFAULT;
   localparam int DRAIN_CYCLES = 3 * DIM + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 10;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = FUNC_MAT;
   logic [ROW_W-1:0]         req_row_index = '0;
   logic [COL_W-1:0]         req_col_index = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ROW_W-1:0]         rsp_out_row;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic                     rsp_saturated;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_NUM_ROWS;
   logic [CFG_W-1:0]         csr_data = '0;

   int failure_count;
   int pending_results;
   int cycle_count = 0;
   int send_idle_pct = 22;
   int recv_idle_pct = 52;
   int active_rows = DIM;
   int active_cols = DIM;
   bit matrix_written [DIM][DIM];
   bit vector_written [DIM];

   matrix_vector_multiply #(.MAX_DIM(DIM)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_row_index(req_row_index), .req_col_index(req_col_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_row(rsp_out_row),
      .rsp_out_value(rsp_out_value), .rsp_saturated(rsp_saturated), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   mvm_checker product_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_row_index(req_row_index), .req_col_index(req_col_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_row(rsp_out_row),
      .rsp_out_value(rsp_out_value), .rsp_saturated(rsp_saturated), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .failure_count(failure_count), .pending_results(pending_results)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] rand_value();
      logic [DATA_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 3))
         0: return raw;
         1: return $signed(raw) >>> $urandom_range(8, 24);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'h00000000;
               default: return 32'hFFFFFFFF;
            endcase
         end
         default: return $signed(raw) >>> 12;
      endcase
   endfunction

   function automatic int clamp_dim(input int d);
      if (d < 1) return 1;
      if (d > DIM) return DIM;
      return d;
   endfunction

   // valid is held from the accepting edge into the next item unless a gap is drawn
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [DATA_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_row_index <= row;
      req_col_index <= col;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (func == FUNC_MAT) matrix_written[row][col] = 1'b1;
      if (func == FUNC_VEC) vector_written[col] = 1'b1;
   endtask

   // make sure every entry the product reads has been loaded first
   task automatic issue_product();
      for (int r = 0; r < active_rows; r++)
         for (int c = 0; c < active_cols; c++)
            if (!matrix_written[r][c])
               send_item(FUNC_MAT, ROW_W'(r), COL_W'(c), rand_value());
      for (int c = 0; c < active_cols; c++)
         if (!vector_written[c]) send_item(FUNC_VEC, ROW_W'($urandom), COL_W'(c), rand_value());
      send_item(FUNC_CALC, ROW_W'($urandom), COL_W'($urandom), $urandom);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      csr_valid <= 1'b1;
      csr_index <= CSR_NUM_ROWS;
      csr_data <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_NUM_COLS;
      csr_data <= cols;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      active_rows = clamp_dim(int'(rows));
      active_cols = clamp_dim(int'(cols));
   endtask

   task automatic run_directed();
      set_dims(5'd1, 5'd1);
      // largest magnitudes, clipped both ways
      send_item(FUNC_MAT, 4'd0, 4'd0, 32'h7FFFFFFF);
      send_item(FUNC_VEC, 4'd15, 4'd0, 32'h7FFFFFFF);
      send_item(FUNC_CALC, 4'd0, 4'd0, 32'h00000000);
      send_item(FUNC_MAT, 4'd0, 4'd0, 32'h80000000);
      send_item(FUNC_CALC, 4'd15, 4'd15, 32'hFFFFFFFF);
      send_item(FUNC_VEC, 4'd9, 4'd0, 32'h80000000);
      send_item(FUNC_CALC, 4'd7, 4'd3, 32'h5A5A5A5A);
      // unused code must leave the stores alone
      send_item(FUNC_UNUSED, 4'd15, 4'd15, 32'hFFFFFFFF);
      send_item(FUNC_UNUSED, 4'd0, 4'd0, 32'h00000000);
      send_item(FUNC_CALC, 4'd0, 4'd0, 32'h00000000);
      // half an lsb rounds up, for both signs
      send_item(FUNC_MAT, 4'd0, 4'd0, 32'h00000001);
      send_item(FUNC_VEC, 4'd0, 4'd0, 32'h00008000);
      send_item(FUNC_CALC, 4'd0, 4'd0, 32'h00000000);
      send_item(FUNC_VEC, 4'd0, 4'd0, 32'h00007FFF);
      send_item(FUNC_CALC, 4'd0, 4'd0, 32'h00000000);
      send_item(FUNC_MAT, 4'd0, 4'd0, 32'hFFFFFFFF);
      send_item(FUNC_VEC, 4'd0, 4'd0, 32'h00008000);
      send_item(FUNC_CALC, 4'd0, 4'd0, 32'h00000000);
      send_item(FUNC_MAT, 4'd0, 4'd0, 32'h00000000);
      send_item(FUNC_CALC, 4'd0, 4'd0, 32'h00000000);
      // far corners of both stores
      send_item(FUNC_MAT, 4'd15, 4'd15, 32'h12345678);
      send_item(FUNC_VEC, 4'd0, 4'd15, 32'hEDCBA988);
   endtask

   initial begin
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      int pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 3) begin
            send_idle_pct <= 52;
            recv_idle_pct <= 22;
         end
         if (phase == 6) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         wait_idle();
         case (phase)
            0: begin rows = 5'd16; cols = 5'd16; end
            1: begin rows = 5'd0;  cols = 5'd0;  end
            2: begin rows = 5'd31; cols = 5'd5;  end
            3: begin rows = 5'd3;  cols = 5'd17; end
            4: begin rows = 5'd16; cols = 5'd1;  end
            5: begin rows = 5'd1;  cols = 5'd16; end
            default: begin
               rows = CFG_W'($urandom_range(0, 31));
               cols = CFG_W'($urandom_range(0, 31));
            end
         endcase
         set_dims(rows, cols);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               send_item(FUNC_MAT, ROW_W'($urandom), COL_W'($urandom), rand_value());
            else if (pick < 60)
               send_item(FUNC_VEC, ROW_W'($urandom), COL_W'($urandom), rand_value());
            else if (pick < 90)
               issue_product();
            else
               send_item(FUNC_UNUSED, ROW_W'($urandom), COL_W'($urandom), $urandom);
         end
      end
      wait_idle();
      if (failure_count == 0 && pending_results == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
